>>> src/ova_pkg.sv
// ova_pkg: shared types and constants for the oldest-first voice allocator
// depends on nothing; imported by ova_voice_ram, oldest_voice_allocator_top and the test bench
package ova_pkg;

  localparam int NOTE_W  = 7;
  localparam int STAMP_W = 32;
  localparam int VOICE_W = 7;
  localparam int OP_W    = 2;
  localparam int COUNT_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd12;

  localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [OP_W-1:0] OP_BCAST    = 2'd2;

  // per-voice stored data; the busy flag lives in flops in the top level
  typedef struct packed {
    logic [NOTE_W-1:0]  note;
    logic [STAMP_W-1:0] stamp;
  } ova_entry_t;

endpackage

>>> src/ova_voice_ram.sv
// ova_voice_ram: one write port, one registered read port voice table
// depends on ova_pkg for the entry type
module ova_voice_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  ova_pkg::ova_entry_t wr_data,
  input  logic [AW-1:0]       rd_addr,
  output ova_pkg::ova_entry_t rd_data
);
  import ova_pkg::*;

  ova_entry_t mem [DEPTH];
  ova_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/oldest_voice_allocator_top.sv
// oldest_voice_allocator_top: oldest-first voice stealing allocator
// depends on ova_pkg and ova_voice_ram
// results: a broadcast is answered from the idle state; a note event runs
//   through the table scan (one entry per cycle, up to n = active voices) and S_FIN
// throughput: one item at a time, the next item can be taken at the edge that
//   takes the result
// reset: synchronous active-low rst_n frees all voices, zeroes the stamp counter
//   and sets voice_count to 12; no clearing pass, results are never stalled
module oldest_voice_allocator_top #(
  parameter int MAX_VOICES = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ova_pkg::OP_W-1:0]      in_op,
  input  logic [ova_pkg::NOTE_W-1:0]    in_note,
  output logic                          out_valid,
  output logic [ova_pkg::VOICE_W-1:0]   out_voice,
  output logic                          out_hit,
  output logic                          out_stolen,
  output logic                          out_broadcast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ova_pkg::COUNT_W-1:0]   cfg_data
);
  import ova_pkg::*;

  // index width of the voice table; count width can also hold MAX_VOICES itself
  localparam int IW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW = IW + 1;
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_VOICES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t                  state_r;
  logic [MAX_VOICES-1:0]   busy_r;          // per-voice sounding flag
  logic [STAMP_W-1:0]      stamp_cnt_r;
  logic [COUNT_W-1:0]      voice_count_r;

  // latched item
  logic [OP_W-1:0]         op_r;
  logic [NOTE_W-1:0]       note_r;
  logic [COUNT_W-1:0]      n_r;             // clamped active voice count

  // scan pipeline: address issue stage and data stage
  logic [CW-1:0]           addr_r;
  logic                    pipe_vld_r;
  logic [IW-1:0]           pipe_idx_r;
  logic [IW-1:0]           best_idx_r;
  logic [STAMP_W-1:0]      best_stamp_r;

  // chosen voice, held for the write-back cycle
  logic [IW-1:0]           vi_r;
  logic                    hit_r;
  logic                    stolen_r;

  // registered result
  logic                    out_valid_r;
  logic [VOICE_W-1:0]      out_voice_r;
  logic                    out_hit_r;
  logic                    out_stolen_r;
  logic                    out_broadcast_r;

  logic [COUNT_W-1:0]      n_nxt;
  logic                    issue;
  logic                    pipe_last;
  logic                    ent_busy;
  ova_entry_t              rd_entry;
  ova_entry_t              wr_entry;
  logic                    wr_en;

  // data stage decisions
  logic                    done;
  logic                    upd_best;
  logic [IW-1:0]           sel_vi;
  logic                    sel_hit;
  logic                    sel_stolen;

  // clamp voice_count into 1..MAX_VOICES
  always_comb begin
    if (voice_count_r == '0) begin
      n_nxt = COUNT_W'(1);
    end else if (voice_count_r > MAX_CNT) begin
      n_nxt = MAX_CNT;
    end else begin
      n_nxt = voice_count_r;
    end
  end

  // one table read issued per cycle while voices remain
  assign issue     = (state_r == S_SCAN) && (COUNT_W'(addr_r) < n_r);
  assign pipe_last = (COUNT_W'(pipe_idx_r) == (n_r - COUNT_W'(1)));
  assign ent_busy  = busy_r[pipe_idx_r];

  // only note-on writes the table: note and stamp of the chosen voice
  assign wr_en          = (state_r == S_FIN) && (op_r == OP_NOTE_ON);
  assign wr_entry.note  = note_r;
  assign wr_entry.stamp = stamp_cnt_r;

  ova_voice_ram #(
    .DEPTH (MAX_VOICES),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (vi_r),
    .wr_data (wr_entry),
    .rd_addr (addr_r[IW-1:0]),
    .rd_data (rd_entry)
  );

  // evaluate the entry that came back from the table this cycle
  always_comb begin
    done       = 1'b0;
    upd_best   = 1'b0;
    sel_vi     = best_idx_r;
    sel_hit    = 1'b0;
    sel_stolen = 1'b0;
    if (pipe_vld_r) begin
      case (op_r)
        OP_NOTE_ON: begin
          if (!ent_busy) begin
            // first free voice wins
            done    = 1'b1;
            sel_vi  = pipe_idx_r;
            sel_hit = 1'b1;
          end else begin
            // track oldest stamp, lowest index on ties
            if ((pipe_idx_r == '0) || (rd_entry.stamp < best_stamp_r)) begin
              upd_best = 1'b1;
            end
            if (pipe_last) begin
              done       = 1'b1;
              sel_vi     = upd_best ? pipe_idx_r : best_idx_r;
              sel_hit    = 1'b1;
              sel_stolen = 1'b1;
            end
          end
        end
        OP_NOTE_OFF: begin
          if (ent_busy && (rd_entry.note == note_r)) begin
            done    = 1'b1;
            sel_vi  = pipe_idx_r;
            sel_hit = 1'b1;
          end else if (pipe_last) begin
            // miss reports voice 0
            done   = 1'b1;
            sel_vi = '0;
          end
        end
        default: begin
          done = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      busy_r        <= '0;
      stamp_cnt_r   <= '0;
      voice_count_r <= COUNT_RESET;
      pipe_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      pipe_vld_r  <= issue;
      pipe_idx_r  <= addr_r[IW-1:0];
      if (issue) begin
        addr_r <= addr_r + CW'(1);
      end

      // cfg always ready; unchecked, sender must write only while nothing is in flight
      if (cfg_valid) begin
        voice_count_r <= cfg_data;
      end

      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r   <= in_op;
            note_r <= in_note;
            n_r    <= n_nxt;
            addr_r <= '0;
            if ((in_op == OP_NOTE_ON) || (in_op == OP_NOTE_OFF)) begin
              state_r <= S_SCAN;
            end else begin
              // broadcast: answer at once, no voice or stamp state touched
              out_valid_r     <= 1'b1;
              out_voice_r     <= '0;
              out_hit_r       <= 1'b0;
              out_stolen_r    <= 1'b0;
              out_broadcast_r <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (upd_best) begin
            best_idx_r   <= pipe_idx_r;
            best_stamp_r <= rd_entry.stamp;
          end
          if (done) begin
            vi_r     <= sel_vi;
            hit_r    <= sel_hit;
            stolen_r <= sel_stolen;
            state_r  <= S_FIN;
          end
        end
        S_FIN: begin
          // write back busy flag and stamp counter, present the result
          if (op_r == OP_NOTE_ON) begin
            busy_r[vi_r] <= 1'b1;
            stamp_cnt_r  <= stamp_cnt_r + STAMP_W'(1);
          end else if (hit_r) begin
            busy_r[vi_r] <= 1'b0;
          end
          out_valid_r     <= 1'b1;
          out_voice_r     <= VOICE_W'(vi_r);
          out_hit_r       <= hit_r;
          out_stolen_r    <= stolen_r;
          out_broadcast_r <= 1'b0;
          state_r         <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_voice     = out_voice_r;
  assign out_hit       = out_hit_r;
  assign out_stolen    = out_stolen_r;
  assign out_broadcast = out_broadcast_r;

  // a stolen voice always comes with a note-on hit
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stolen) |-> (out_hit && !out_broadcast))
    else $error("stolen result without note-on hit");

  // scan data never comes from beyond the active voices
  assert property (@(posedge clk) disable iff (!rst_n)
    pipe_vld_r |-> (COUNT_W'(pipe_idx_r) < n_r))
    else $error("scan read past active voice count");

  // every note-on write-back advances the stamp counter by one
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && op_r == OP_NOTE_ON) |=>
      (stamp_cnt_r == $past(stamp_cnt_r) + STAMP_W'(1)))
    else $error("stamp counter did not advance on note-on");

  // a note item accepted while idle makes the block busy next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == OP_NOTE_ON || in_op == OP_NOTE_OFF)) |=> busy)
    else $error("note item accepted but block not busy");

endmodule

>>> sim/oldest_voice_allocator_top_test.sv
`timescale 1ns / 1ps
// oldest_voice_allocator_top_test: self-checking bench for the oldest-first voice allocator
// depends on ova_pkg and oldest_voice_allocator_top; keeps its own copy of the voice
// table, predicts every result and compares field by field

module oldest_voice_allocator_top_test;
  import ova_pkg::*;

  localparam int NUM_VOICES  = 128;
  // slowest run is roughly 1100 items plus gaps, far inside this limit
  localparam int CYCLE_LIMIT = 1000000;
  // worst-case scan latency with some margin, used for the final quiet period
  localparam int DRAIN_WAIT  = NUM_VOICES + 16;
  // op code the block treats like a broadcast
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  // random phases: polyphony, item count, note-on share and idle share in percent
  localparam int NUM_PHASES = 9;
  localparam int PHASE_COUNT [NUM_PHASES] = '{128, 4, 1, 0, 12, 0, 0, 7, 0};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{230, 130, 80, 60, 150, 130, 120, 80, 100};
  localparam int PHASE_ON    [NUM_PHASES] = '{80, 50, 50, 45, 55, 60, 65, 50, 55};
  localparam int PHASE_IDLE  [NUM_PHASES] = '{25, 35, 0, 25, 40, 20, 30, 25, 0};

  // one result item as the block presents it
  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic               hit;
    logic               stolen;
    logic               broadcast;
  } alloc_result_t;

  // voice table model plus the queue of results still owed by the block
  class voice_tracker;
    bit                 voice_on    [NUM_VOICES];
    logic [NOTE_W-1:0]  voice_note  [NUM_VOICES];
    logic [STAMP_W-1:0] voice_stamp [NUM_VOICES];
    logic [STAMP_W-1:0] stamp_ctr;
    logic [COUNT_W-1:0] voice_count;
    alloc_result_t      owed_results[$];
    int                 errors;

    function new();
      foreach (voice_on[i]) begin
        voice_on[i]    = 1'b0;
        voice_note[i]  = '0;
        voice_stamp[i] = '0;
      end
      stamp_ctr   = '0;
      voice_count = COUNT_RESET;
      errors      = 0;
    endfunction

    function void set_count(logic [COUNT_W-1:0] value);
      voice_count = value;
    endfunction

    // zero counts as one voice, anything past the table saturates
    function int active_voices();
      if (voice_count == 0) return 1;
      if (voice_count > NUM_VOICES) return NUM_VOICES;
      return int'(voice_count);
    endfunction

    // update the table for one accepted item and queue the result it owes
    function void apply_event(logic [OP_W-1:0] op, logic [NOTE_W-1:0] note);
      alloc_result_t      res;
      int                 n;
      int                 pick;
      logic [STAMP_W-1:0] oldest;
      bit                 found_free;
      res        = '0;
      n          = active_voices();
      pick       = 0;
      oldest     = '0;
      found_free = 1'b0;
      case (op)
        OP_NOTE_ON: begin
          for (int i = 0; i < n; i++) begin
            if (!voice_on[i]) begin
              pick       = i;
              found_free = 1'b1;
              break;
            end
            if (i == 0 || voice_stamp[i] < oldest) begin
              pick   = i;
              oldest = voice_stamp[i];
            end
          end
          voice_on[pick]    = 1'b1;
          voice_note[pick]  = note;
          voice_stamp[pick] = stamp_ctr;
          stamp_ctr         = stamp_ctr + 1;
          res.voice  = VOICE_W'(pick);
          res.hit    = 1'b1;
          res.stolen = !found_free;
        end
        OP_NOTE_OFF: begin
          for (int i = 0; i < n; i++) begin
            if (voice_on[i] && voice_note[i] == note) begin
              voice_on[i] = 1'b0;
              res.voice   = VOICE_W'(i);
              res.hit     = 1'b1;
              break;
            end
          end
        end
        default: begin
          res.broadcast = 1'b1;
        end
      endcase
      owed_results.push_back(res);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp;
      if (owed_results.size() == 0) begin
        $error("result with no item waiting: voice %0d hit %0d stolen %0d broadcast %0d",
               got.voice, got.hit, got.stolen, got.broadcast);
        errors++;
        return;
      end
      exp = owed_results.pop_front();
      if (got.voice !== exp.voice) begin
        $error("voice: expected %0d, got %0d", exp.voice, got.voice);
        errors++;
      end
      if (got.hit !== exp.hit) begin
        $error("hit: expected %0d, got %0d", exp.hit, got.hit);
        errors++;
      end
      if (got.stolen !== exp.stolen) begin
        $error("stolen: expected %0d, got %0d", exp.stolen, got.stolen);
        errors++;
      end
      if (got.broadcast !== exp.broadcast) begin
        $error("broadcast: expected %0d, got %0d", exp.broadcast, got.broadcast);
        errors++;
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  // all block inputs start at known values
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic [OP_W-1:0]     in_op     = '0;
  logic [NOTE_W-1:0]   in_note   = '0;
  logic                cfg_valid = 1'b0;
  logic [COUNT_W-1:0]  cfg_data  = '0;
  logic                busy;
  logic                out_valid;
  logic [VOICE_W-1:0]  out_voice;
  logic                out_hit;
  logic                out_stolen;
  logic                out_broadcast;
  logic                cfg_ready;

  voice_tracker tracker;
  int           cycle_count = 0;

  oldest_voice_allocator_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_note      (in_note),
    .out_valid    (out_valid),
    .out_voice    (out_voice),
    .out_hit      (out_hit),
    .out_stolen   (out_stolen),
    .out_broadcast(out_broadcast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[oldest_voice_allocator_top] ERROR");
      $finish;
    end
  end

  // watch both channels at each edge; the result is checked before a new item is
  // recorded, since a result and the next accept can share an edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_result({out_voice, out_hit, out_stolen, out_broadcast});
      if (start && !busy) tracker.apply_event(in_op, in_note);
    end
  end

  // present one item and hold it until the block takes it; start stays high on
  // return so the caller's next drive is the only update in this step
  task automatic send_item(input logic [OP_W-1:0] op, input logic [NOTE_W-1:0] note);
    in_op   <= op;
    in_note <= note;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending and wait until every owed result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // polyphony may only change while the block is idle
  task automatic write_voice_count(input logic [COUNT_W-1:0] value);
    drain();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_count(value);
  endtask

  // random traffic: notes mostly from a narrow window so note-offs often find
  // their voice, the rest over the whole range; broadcasts use both codes
  task automatic run_phase(input int items, input int on_pct, input int idle_pct,
                           input int pause_at);
    int               roll;
    int               base;
    logic [OP_W-1:0]  op;
    logic [NOTE_W-1:0] note;
    base = $urandom_range(0, 116);
    for (int k = 0; k < items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < on_pct) op = OP_NOTE_ON;
      else if (roll < on_pct + (100 - on_pct) * 3 / 4) op = OP_NOTE_OFF;
      else op = $urandom_range(0, 1) ? OP_BCAST : OP_RESERVED;
      if ($urandom_range(0, 3) != 0) note = NOTE_W'(base + $urandom_range(0, 11));
      else note = NOTE_W'($urandom_range(0, 127));
      if (k == pause_at) drain();
      else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        idle_cycles($urandom_range(1, 4));
      send_item(op, note);
    end
  endtask

  initial begin
    int count_value;
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default polyphony of 12: miss on an empty table, both broadcast codes,
    // note extremes, a hit that frees voice 0 and its reuse
    send_item(OP_NOTE_OFF, 7'd0);
    send_item(OP_NOTE_ON, 7'd127);
    send_item(OP_NOTE_ON, 7'd0);
    send_item(OP_BCAST, 7'd127);
    send_item(OP_RESERVED, 7'd85);
    send_item(OP_NOTE_OFF, 7'd127);
    send_item(OP_NOTE_ON, 7'd42);
    send_item(OP_NOTE_OFF, 7'd99);

    // zero voices acts as one: every note-on lands on voice 0, stealing it while busy
    write_voice_count(8'd0);
    send_item(OP_NOTE_ON, 7'd10);
    send_item(OP_NOTE_ON, 7'd11);
    send_item(OP_NOTE_OFF, 7'd11);
    send_item(OP_NOTE_ON, 7'd12);

    // three voices: fill up, then oldest-first stealing
    write_voice_count(8'd3);
    send_item(OP_NOTE_ON, 7'd1);
    send_item(OP_NOTE_ON, 7'd2);
    send_item(OP_NOTE_ON, 7'd3);
    send_item(OP_NOTE_ON, 7'd4);
    send_item(OP_NOTE_ON, 7'd5);

    // all-ones count saturates to the full table; voices left over above the old
    // count join the scan again
    write_voice_count(8'd255);
    send_item(OP_NOTE_ON, 7'd127);
    send_item(OP_NOTE_OFF, 7'd0);
    send_item(OP_NOTE_OFF, 7'd127);

    // random phases, each with its own polyphony; the last one runs without gaps
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        5:       count_value = $urandom_range(2, 127);
        6:       count_value = $urandom_range(129, 255);
        8:       count_value = $urandom_range(1, 20);
        default: count_value = PHASE_COUNT[p];
      endcase
      write_voice_count(COUNT_W'(count_value));
      run_phase(PHASE_ITEMS[p], PHASE_ON[p], PHASE_IDLE[p], (p == 4) ? 75 : -1);
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d expected results never arrived", tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("[oldest_voice_allocator_top] OK");
    end else begin
      $display("[oldest_voice_allocator_top] ERROR");
    end
    $finish;
  end

endmodule
